[hw/rtl/bmhq_pkg.sv]
// Shared types and constants of the binary min-heap priority queue.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 23;
  localparam int TAG_W        = 32;
  localparam int ENT_W        = KEY_W + TAG_W;
  localparam int FILL_W       = 9;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 64;

  typedef enum logic {
    FN_INSERT  = 1'b0,
    FN_EXTRACT = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;    // capture input word, clear result
    status_t code;      // result status captured on accept
    logic    inc_count;
    logic    rd_up;     // read parent of pos on port A
    logic    up_move;   // parent moves down into pos
    logic    rd_ex;     // read root on port A, last entry on port B
    logic    ex_load;   // take root as result, last entry as hold
    logic    rd_dn;     // read both children of pos
    logic    dn_move;   // smaller child moves up into pos
    logic    place;     // write hold into pos
    logic    out_load;  // present result on the master side
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic at_root;
    logic up_less;
    logic has_child;
    logic dn_less;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/binary_min_heap_queue_core.sv]
// An insert climbs one level per parent check and compare until it is not below the parent or
// is at the root, then is placed; an extract takes the root as result and the last entry as
// hold, then descends one level per child check and compare until no child is smaller or it
// is at a leaf; taking the last entry skips the descent. A flagged word goes straight to the
// finish, which loads the output word; one word is in work at a time, and a held output word
// stalls the next one. Reset clears the controller, fill count and output valid only.
`default_nettype none

module binary_min_heap_queue_core #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [bmhq_pkg::IN_DATA_W-1:0]      s_tdata,  // date_key, item_tag, pad
  input  wire logic                                s_tuser,  // func
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [bmhq_pkg::OUT_DATA_W-1:0]          m_tdata,  // out_date_key, out_item_tag,
                                                             // fill_count
  output logic [bmhq_pkg::STATUS_W-1:0]            m_tuser   // status
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  bmhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_key   (s_tdata[bmhq_pkg::KEY_W-1:0]),
    .in_tag   (s_tdata[bmhq_pkg::ENT_W-1:bmhq_pkg::KEY_W]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/bmhq_ctrl.sv]
// Sequencer of the heap queue: insert sift-up and extract sift-down steps.
`default_nettype none

module bmhq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic            func,
  output bmhq_pkg::cmd_t       cmd,
  input  wire bmhq_pkg::sts_t  sts
);

  bmhq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = bmhq_pkg::ST_OK;
    s_tready   = 1'b0;
    unique case (state)
      bmhq_pkg::S_IDLE: begin
        // hold off the slave side while in reset
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.accept = 1'b1;
          if (bmhq_pkg::func_t'(func) == bmhq_pkg::FN_INSERT) begin
            if (sts.full) begin
              cmd.code   = bmhq_pkg::ST_FULL;
              state_next = bmhq_pkg::S_FINISH;
            end else begin
              cmd.inc_count = 1'b1;
              state_next    = bmhq_pkg::S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              cmd.code   = bmhq_pkg::ST_EMPTY;
              state_next = bmhq_pkg::S_FINISH;
            end else begin
              cmd.rd_ex  = 1'b1;
              state_next = bmhq_pkg::S_EX_LD;
            end
          end
        end
      end
      bmhq_pkg::S_UP_CHK: begin
        if (sts.at_root) begin
          cmd.place  = 1'b1;
          state_next = bmhq_pkg::S_FINISH;
        end else begin
          cmd.rd_up  = 1'b1;
          state_next = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.up_move = 1'b1;
          state_next  = bmhq_pkg::S_UP_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = bmhq_pkg::S_FINISH;
        end
      end
      bmhq_pkg::S_EX_LD: begin
        cmd.ex_load = 1'b1;
        // the root was the only entry: nothing left to sift
        state_next  = sts.one_left ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DN_CHK;
      end
      bmhq_pkg::S_DN_CHK: begin
        if (sts.has_child) begin
          cmd.rd_dn  = 1'b1;
          state_next = bmhq_pkg::S_DN_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = bmhq_pkg::S_FINISH;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        if (sts.dn_less) begin
          cmd.dn_move = 1'b1;
          state_next  = bmhq_pkg::S_DN_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = bmhq_pkg::S_FINISH;
        end
      end
      bmhq_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // at most one memory write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.place, cmd.up_move, cmd.dn_move}))
    else $error("bmhq_ctrl: conflicting memory writes");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("bmhq_ctrl: result loaded over a pending word");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (state == bmhq_pkg::S_IDLE && s_tvalid) |=> state != bmhq_pkg::S_IDLE)
    else $error("bmhq_ctrl: accepted word not processed");

endmodule

`default_nettype wire

[hw/rtl/bmhq_dpath.sv]
// Heap storage, sift position, moving entry, fill counter and result register.
`default_nettype none

module bmhq_dpath #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bmhq_pkg::cmd_t                  cmd,
  output bmhq_pkg::sts_t                       sts,
  input  wire logic [bmhq_pkg::KEY_W-1:0]      in_key,
  input  wire logic [bmhq_pkg::TAG_W-1:0]      in_tag,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic [bmhq_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [bmhq_pkg::STATUS_W-1:0]        m_tuser
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int KEY_W  = bmhq_pkg::KEY_W;
  localparam int TAG_W  = bmhq_pkg::TAG_W;
  localparam int ENT_W  = bmhq_pkg::ENT_W;
  localparam int FILL_W = bmhq_pkg::FILL_W;

  // entry layout: tag above key
  logic [ENT_W-1:0]  mem [CAPACITY];
  logic [ENT_W-1:0]  rd_a, rd_b;
  logic [ENT_W-1:0]  hold;
  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0]  count;

  logic [KEY_W-1:0]     res_key;
  logic [TAG_W-1:0]     res_tag;
  bmhq_pkg::status_t    res_status;

  logic [ADDR_W-1:0] pos_m1, parent;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  lc, rc, cnt_ext;
  logic              rc_valid, take_rc;
  logic [ENT_W-1:0]  cand;
  logic [ADDR_W-1:0] cand_idx;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [ENT_W-1:0]  wdata;
  logic              wen;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign pos_m1   = pos - 1'b1;
  assign parent   = ADDR_W'(pos_m1 >> 1);
  assign cnt_m1   = count - 1'b1;
  assign lc       = {1'b0, pos, 1'b1};
  assign rc       = lc + IDX_W'(1);
  assign cnt_ext  = IDX_W'(count);
  assign rc_valid = rc < cnt_ext;
  // left child wins a tie
  assign take_rc  = rc_valid && (rd_b[KEY_W-1:0] < rd_a[KEY_W-1:0]);
  assign cand     = take_rc ? rd_b : rd_a;
  assign cand_idx = take_rc ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

  always_comb begin
    sts.full      = (count == CNT_W'(CAPACITY));
    sts.empty     = (count == '0);
    sts.one_left  = (count == CNT_W'(1));
    sts.at_root   = (pos == '0);
    sts.up_less   = hold[KEY_W-1:0] < rd_a[KEY_W-1:0];
    sts.has_child = lc < cnt_ext;
    sts.dn_less   = cand[KEY_W-1:0] < hold[KEY_W-1:0];
    sts.out_busy  = m_tvalid && !m_tready;
  end

  always_comb begin
    addr_a = '0;
    addr_b = cnt_m1[ADDR_W-1:0];
    if (cmd.rd_up) begin
      addr_a = parent;
    end else if (cmd.rd_dn) begin
      addr_a = lc[ADDR_W-1:0];
      addr_b = rc[ADDR_W-1:0];
    end
  end

  always_comb begin
    wen   = cmd.place || cmd.up_move || cmd.dn_move;
    wdata = hold;
    if (cmd.up_move) begin
      wdata = rd_a;
    end else if (cmd.dn_move) begin
      wdata = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[pos] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_up || cmd.rd_ex || cmd.rd_dn) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold       <= {in_tag, in_key};
      pos        <= count[ADDR_W-1:0];
      res_key    <= '0;
      res_tag    <= '0;
      res_status <= cmd.code;
    end else if (cmd.ex_load) begin
      hold    <= rd_b;
      pos     <= '0;
      res_key <= rd_a[KEY_W-1:0];
      res_tag <= rd_a[ENT_W-1:KEY_W];
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.dn_move) begin
      pos <= cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.inc_count) begin
      count <= count + CNT_W'(1);
    end else if (cmd.ex_load) begin
      count <= cnt_m1;
    end
  end

  assign fill_ext = (CNT_W + FILL_W)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {fill_ext[FILL_W-1:0], res_tag, res_key};
      m_tuser <= res_status;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("bmhq_dpath: fill count above capacity");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.inc_count |=> count == $past(count) + CNT_W'(1))
    else $error("bmhq_dpath: insert did not grow the heap");

  // a waiting result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("bmhq_dpath: pending result word changed");

endmodule

`default_nettype wire

[tb/binary_min_heap_queue_core_tb.sv]
// Self-checking testbench for the binary min-heap priority queue core.
`timescale 1ns / 100ps

module binary_min_heap_queue_core_tb;

  localparam int HEAP_CAP    = bmhq_pkg::CAPACITY_DEF;
  localparam int KEY_W       = bmhq_pkg::KEY_W;
  localparam int TAG_W       = bmhq_pkg::TAG_W;
  localparam int FILL_W      = bmhq_pkg::FILL_W;
  localparam int MAX_KEY     = 5119999;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_AFTER  = 400;

  typedef struct {
    bmhq_pkg::func_t  fn;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } heap_op_t;

  typedef struct {
    bmhq_pkg::status_t st;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [FILL_W-1:0] fill;
  } heap_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bmhq_pkg::IN_DATA_W-1:0]  s_tdata = '0;  // date_key, item_tag, pad
  logic                            s_tuser = bmhq_pkg::FN_INSERT;  // func
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bmhq_pkg::OUT_DATA_W-1:0] m_tdata;  // out_date_key, out_item_tag, fill_count
  logic [bmhq_pkg::STATUS_W-1:0]   m_tuser;  // status

  binary_min_heap_queue_core #(.CAPACITY(HEAP_CAP)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Mirror of the heap contents
  logic [KEY_W-1:0] heap_key [HEAP_CAP];
  logic [TAG_W-1:0] heap_tag [HEAP_CAP];
  int               heap_cnt = 0;

  heap_op_t     op_q[$];
  heap_result_t outcome_q[$];

  int err_cnt      = 0;
  int taken_cnt    = 0;
  int n_insert     = 0;
  int n_extract    = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int peak_fill    = 0;
  int cycle_cnt    = 0;
  logic in_acc     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Apply one operation to the mirror heap and return the word it should produce.
  function automatic heap_result_t heap_apply(bmhq_pkg::func_t fn, logic [KEY_W-1:0] k,
                                              logic [TAG_W-1:0] t);
    heap_result_t     r;
    int               pos;
    int               up;
    int               best;
    int               lc;
    int               rc;
    logic [KEY_W-1:0] tk;
    logic [TAG_W-1:0] tt;
    r.st  = bmhq_pkg::ST_OK;
    r.key = '0;
    r.tag = '0;
    if (fn == bmhq_pkg::FN_INSERT) begin
      n_insert++;
      if (heap_cnt >= HEAP_CAP) begin
        r.st = bmhq_pkg::ST_FULL;
        n_full++;
      end else begin
        heap_key[heap_cnt] = k;
        heap_tag[heap_cnt] = t;
        pos = heap_cnt;
        heap_cnt++;
        // climb while strictly below the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_key[pos] < heap_key[up])) break;
          tk = heap_key[pos]; tt = heap_tag[pos];
          heap_key[pos] = heap_key[up]; heap_tag[pos] = heap_tag[up];
          heap_key[up] = tk; heap_tag[up] = tt;
          pos = up;
        end
      end
    end else begin
      n_extract++;
      if (heap_cnt == 0) begin
        r.st = bmhq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.key = heap_key[0];
        r.tag = heap_tag[0];
        heap_cnt--;
        heap_key[0] = heap_key[heap_cnt];
        heap_tag[0] = heap_tag[heap_cnt];
        pos = 0;
        // descend; the right child wins only when strictly below the left
        while (heap_cnt > 0) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < heap_cnt && heap_key[lc] < heap_key[best]) best = lc;
          if (rc < heap_cnt && heap_key[rc] < heap_key[best]) best = rc;
          if (best == pos) break;
          tk = heap_key[pos]; tt = heap_tag[pos];
          heap_key[pos] = heap_key[best]; heap_tag[pos] = heap_tag[best];
          heap_key[best] = tk; heap_tag[best] = tt;
          pos = best;
        end
      end
    end
    if (heap_cnt > peak_fill) peak_fill = heap_cnt;
    r.fill = heap_cnt[FILL_W-1:0];
    return r;
  endfunction

  // Check result words first, then predict the word taken on this edge.
  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        taken_cnt++;
        if (outcome_q.size() == 0) begin
          flag_mismatch("unexpected word", longint'(m_tdata), longint'(0));
        end else begin
          want = outcome_q.pop_front();
          if (m_tuser != want.st)
            flag_mismatch("status", longint'(m_tuser), longint'(want.st));
          if (m_tdata[KEY_W-1:0] != want.key)
            flag_mismatch("out_date_key", longint'(m_tdata[KEY_W-1:0]), longint'(want.key));
          if (m_tdata[KEY_W+TAG_W-1:KEY_W] != want.tag)
            flag_mismatch("out_item_tag", longint'(m_tdata[KEY_W+TAG_W-1:KEY_W]),
                          longint'(want.tag));
          if (m_tdata[KEY_W+TAG_W+FILL_W-1:KEY_W+TAG_W] != want.fill)
            flag_mismatch("fill_count", longint'(m_tdata[KEY_W+TAG_W+FILL_W-1:KEY_W+TAG_W]),
                          longint'(want.fill));
        end
      end
      if (s_tvalid && s_tready)
        outcome_q.insert(outcome_q.size(),
                         heap_apply(bmhq_pkg::func_t'(s_tuser), s_tdata[KEY_W-1:0],
                                    s_tdata[KEY_W+TAG_W-1:KEY_W]));
    end
  end

  // Sender: bursts of words separated by random gaps.
  int gap_left   = 0;
  int burst_left = 0;

  always @(negedge clk) begin
    heap_op_t op;
    logic     nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !in_acc)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_q.size() > 0) begin
        op = op_q.pop_front();
        nv = 1'b1;
        s_tdata <= {1'b0, op.tag, op.key};
        s_tuser <= op.fn;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      s_tvalid <= nv;
    end
  end

  // Receiver: stall modes of random length, plus one long hold-off.
  int   hold_left = 0;
  int   mode      = 0;
  int   mode_left = 0;
  logic long_done = 1'b0;

  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_done && taken_cnt >= HOLD_AFTER) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: begin
            rdy = 1'b1;
          end
          1: begin
            rdy = 1'($urandom_range(0, 1));
          end
          default: begin
            rdy = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
      m_tready <= rdy;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    // half the keys come from a tiny range so ties are common
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, 15));
    return KEY_W'($urandom_range(0, MAX_KEY));
  endfunction

  task automatic add_op(input bmhq_pkg::func_t fn, input logic [KEY_W-1:0] k,
                        input logic [TAG_W-1:0] t);
    heap_op_t op;
    op.fn  = fn;
    op.key = k;
    op.tag = t;
    op_q.insert(op_q.size(), op);
  endtask

  task automatic add_mix(input int n, input int ins_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= ins_pct)
        add_op(bmhq_pkg::FN_INSERT, pick_key(), $urandom);
      else
        add_op(bmhq_pkg::FN_EXTRACT, KEY_W'($urandom_range(0, MAX_KEY)), $urandom);
    end
  endtask

  initial begin
    // Directed: empty extract, key and tag extremes, ties at root and among children
    add_op(bmhq_pkg::FN_EXTRACT, 23'd0, 32'd0);
    add_op(bmhq_pkg::FN_INSERT, KEY_W'(MAX_KEY), 32'hFFFF_FFFF);
    add_op(bmhq_pkg::FN_INSERT, 23'd0, 32'd0);
    add_op(bmhq_pkg::FN_INSERT, 23'd0, 32'hFFFF_FFFF);
    add_op(bmhq_pkg::FN_INSERT, 23'd2600000, 32'h5A5A_5A5A);
    add_op(bmhq_pkg::FN_INSERT, 23'd100, 32'd1);
    add_op(bmhq_pkg::FN_INSERT, 23'd100, 32'd2);
    add_op(bmhq_pkg::FN_INSERT, 23'd100, 32'd3);
    add_op(bmhq_pkg::FN_INSERT, 23'd100, 32'd4);
    add_op(bmhq_pkg::FN_INSERT, 23'd50, 32'hA5A5_A5A5);
    for (int i = 0; i < 10; i++) add_op(bmhq_pkg::FN_EXTRACT, KEY_W'(MAX_KEY), 32'hFFFF_FFFF);
    // Random: mixed growth, fill past full, drain past empty, balanced mix
    add_mix(300, 60);
    add_mix(280, 100);
    add_mix(280, 0);
    add_mix(320, 50);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (op_q.size() != 0 || s_tvalid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Ran %0d inserts (%0d on a full heap) and %0d extracts (%0d on an empty heap),",
             n_insert, n_full, n_extract, n_empty);
    $display("peak fill %0d of %0d, %0d result words checked, %0d mismatches.",
             peak_fill, HEAP_CAP, taken_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[binary_min_heap_queue_core.f]
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/bmhq_dpath.sv
hw/rtl/binary_min_heap_queue_core.sv
tb/binary_min_heap_queue_core_tb.sv
